@@ sv/perlin_noise_2d_octaves_core_defines.svh @@
// Assertion macros used by the top module of the noise core.
`ifndef PERLIN_NOISE_2D_OCTAVES_CORE_DEFINES_SVH
`define PERLIN_NOISE_2D_OCTAVES_CORE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define PN_ASSERT_HOLDS(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define PN_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/pnoise_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pnoise_pkg;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [1:0] CSR_BASE_SCALE   = 2'd0;
   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd1;
   localparam logic [1:0] CSR_ROUGHNESS    = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [24:0] FADE_K15     = 25'd983040;
   localparam logic [20:0] FADE_K10     = 21'd655360;
   localparam logic [23:0] BASE_RESET   = 24'd65536;
   localparam logic [3:0]  OCT_RESET    = 4'd4;
   localparam logic [16:0] ROUGH_RESET  = 17'd32768;
   localparam logic signed [27:0] NOISE_LIMIT = 28'sd4194304;

   typedef struct packed {
      logic [MUL_A_W-1:0] op_a;
      logic [MUL_B_W-1:0] op_b;
   } mul_op_type;

   // Gradient weight of a hash: 1..8 from the low three bits, negative when bit 3 is set.
   function automatic logic signed [4:0] grad_weight(input logic [3:0] h);
      logic [4:0] mag;
      mag = {2'b00, h[2:0]} + 5'd1;
      grad_weight = h[3] ? $signed(-mag) : $signed(mag);
   endfunction

endpackage

`default_nettype wire

@@ sv/pnoise_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier with a registered product.
module pnoise_mul (
   input  wire logic                                   clock,
   input  wire pnoise_pkg::mul_op_type                 op,
   output logic signed [pnoise_pkg::PROD_W-1:0]        prod_ff
);

   logic signed [pnoise_pkg::PROD_W-1:0] prod_in;

   assign prod_in = $signed(op.op_a) * $signed(op.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

@@ sv/pnoise_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Permutation table: one write port, one read port with registered data.
module pnoise_table #(
   parameter int TABLE_SIZE = 256
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
   output logic      [7:0]                    rd_data_ff
);

   logic [7:0] mem [TABLE_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sv/perlin_noise_2d_octaves_core.sv @@
// Load transfer: writes one table entry and gives no result.
// Evaluate transfer: the sequencer runs the N octaves in turn and then presents the result,
// or goes straight to the result with no octaves; the next request is accepted only once
// the sequencer is idle again, later while a finished result waits for the previous one to be taken.
// The octave schedule is set by the one shared multiplier and the single table read port.
// Reset (synchronous, active high) clears the sequencer and the output valid and loads
// the configuration reset values; the permutation table is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
`include "perlin_noise_2d_octaves_core_defines.svh"

// Two-dimensional gradient noise summed over octaves in Q.16 fixed point.
// The sequencer walks a fixed schedule per octave. Each step issues at most one
// multiply on the shared unit and one table read; both return a registered result that
// is ready at the next step, so every step consumes what the step before it issued.
// TABLE_SIZE is a power of two so that all table indexing wraps by truncation.
module perlin_noise_2d_octaves_core #(
   parameter int TABLE_SIZE  = 256,
   parameter int MAX_OCTAVES = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel.
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_type,
   input  wire logic [7:0]         req_table_index,
   input  wire logic [7:0]         req_table_value,
   input  wire logic signed [31:0] req_x_coord,
   input  wire logic signed [31:0] req_y_coord,
   // Response channel.
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [23:0]      rsp_noise_value,
   // Configuration write port.
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [23:0]        csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int PW     = pnoise_pkg::PROD_W;

   // Sequencer codes. The STEP codes form the schedule of one octave.
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_PX     = 5'd1;
   localparam logic [4:0] S_PY     = 5'd2;
   localparam logic [4:0] S_PYW    = 5'd3;
   localparam logic [4:0] S_SHIFT  = 5'd4;
   localparam logic [4:0] S_STEP1  = 5'd5;
   localparam logic [4:0] S_STEP2  = 5'd6;
   localparam logic [4:0] S_STEP3  = 5'd7;
   localparam logic [4:0] S_STEP4  = 5'd8;
   localparam logic [4:0] S_STEP5  = 5'd9;
   localparam logic [4:0] S_STEP6  = 5'd10;
   localparam logic [4:0] S_STEP7  = 5'd11;
   localparam logic [4:0] S_STEP8  = 5'd12;
   localparam logic [4:0] S_STEP9  = 5'd13;
   localparam logic [4:0] S_STEP10 = 5'd14;
   localparam logic [4:0] S_STEP11 = 5'd15;
   localparam logic [4:0] S_STEP12 = 5'd16;
   localparam logic [4:0] S_STEP13 = 5'd17;
   localparam logic [4:0] S_STEP14 = 5'd18;
   localparam logic [4:0] S_STEP15 = 5'd19;
   localparam logic [4:0] S_STEP16 = 5'd20;
   localparam logic [4:0] S_STEP17 = 5'd21;
   localparam logic [4:0] S_STEP18 = 5'd22;
   localparam logic [4:0] S_STEP19 = 5'd23;
   localparam logic [4:0] S_STEP20 = 5'd24;
   localparam logic [4:0] S_DONE   = 5'd25;

   // Configuration registers.
   logic [23:0] csr_base_scale_ff, csr_base_scale_in;
   logic [3:0]  csr_octave_count_ff, csr_octave_count_in;
   logic [16:0] csr_roughness_ff, csr_roughness_in;

   // Sequencer and per-sample state.
   logic [4:0]              state_ff, state_in;
   logic signed [31:0]      x_ff, x_in, y_ff, y_in;
   logic signed [PW-1:0]    px_ff, px_in, py_ff, py_in;
   logic [OCT_W-1:0]        count_ff, count_in, oct_ff, oct_in;
   logic [16:0]             rough_ff, rough_in, amp_ff, amp_in;
   logic signed [27:0]      total_ff, total_in;

   // Per-octave working registers.
   logic [ADDR_W-1:0]       cx_ff, cx_in, cy_ff, cy_in, ra_ff, ra_in, rb_ff, rb_in;
   logic [15:0]             fx_ff, fx_in, fy_ff, fy_in;
   logic [15:0]             fax_ff, fax_in, fay_ff, fay_in;
   logic [20:0]             cvx_ff, cvx_in, cvy_ff, cvy_in;
   logic [16:0]             u_ff, u_in, v_ff, v_in;
   logic [3:0]              h00_ff, h00_in, h01_ff, h01_in, h10_ff, h10_in, h11_ff, h11_in;
   logic signed [23:0]      g00_ff, g00_in, g01_ff, g01_in, g10_ff, g10_in, g11_ff, g11_in;
   logic signed [23:0]      l0_ff, l0_in, l1_ff, l1_in, n_ff, n_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [23:0]      rsp_noise_ff, rsp_noise_in;

   // Shared units.
   pnoise_pkg::mul_op_type  mul_op;
   logic signed [PW-1:0]    prod_ff;
   logic [ADDR_W-1:0]       tbl_raddr;
   logic [7:0]              tbl_rdata_ff;
   logic                    tbl_we;
   logic [ADDR_W-1:0]       tbl_waddr;

   logic                    req_xfer;
   logic [ADDR_W-1:0]       rd_idx;
   logic [4:0]              shamt;
   logic signed [PW-1:0]    sx, sy;
   logic [24:0]             poly_x, poly_y;
   logic [OCT_W-1:0]        oct_next;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   // Table words are taken modulo the table size when used as an index.
   assign rd_idx    = ADDR_W'({{ADDR_W{1'b0}}, tbl_rdata_ff});
   assign tbl_we    = req_xfer && (req_type == pnoise_pkg::REQ_LOAD);
   assign tbl_waddr = ADDR_W'({{ADDR_W{1'b0}}, req_table_index});

   // Octave i samples the point at frequency base_scale * 2^i, which is the
   // scaled product shifted right by 16 - i; cell and fraction are bit fields.
   assign shamt = 5'd16 - 5'(oct_ff);
   assign sx    = px_ff >>> shamt;
   assign sy    = py_ff >>> shamt;

   // Middle term of the fade polynomial: 6f - 15.0 in Q.16.
   assign poly_x = ({8'd0, fx_ff, 1'b0} + {7'd0, fx_ff, 2'b00}) - pnoise_pkg::FADE_K15;
   assign poly_y = ({8'd0, fy_ff, 1'b0} + {7'd0, fy_ff, 2'b00}) - pnoise_pkg::FADE_K15;

   assign oct_next = oct_ff + OCT_W'(1);

   pnoise_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod_ff)
   );

   pnoise_table #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_table (
      .clock      (clock),
      .wr_en      (tbl_we),
      .wr_addr    (tbl_waddr),
      .wr_data    (req_table_value),
      .rd_addr    (tbl_raddr),
      .rd_data_ff (tbl_rdata_ff)
   );

   // Configuration writes; an index past the register list is dropped.
   always_comb begin
      csr_base_scale_in   = csr_base_scale_ff;
      csr_octave_count_in = csr_octave_count_ff;
      csr_roughness_in    = csr_roughness_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pnoise_pkg::CSR_BASE_SCALE:   csr_base_scale_in   = csr_wdata;
            pnoise_pkg::CSR_OCTAVE_COUNT: csr_octave_count_in = csr_wdata[3:0];
            pnoise_pkg::CSR_ROUGHNESS:    csr_roughness_in    = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // Builds the multiplier operands for a gradient: the chosen offset times the weight.
   function automatic pnoise_pkg::mul_op_type grad_op(input logic [3:0] h,
                                                      input logic [16:0] dx,
                                                      input logic [16:0] dy);
      logic [16:0] off;
      logic signed [4:0] w;
      off = h[0] ? dx : dy;
      w   = pnoise_pkg::grad_weight(h);
      grad_op.op_a = {{16{off[16]}}, off};
      grad_op.op_b = {{20{w[4]}}, w};
   endfunction

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      count_in  = count_ff;
      oct_in    = oct_ff;
      rough_in  = rough_ff;
      amp_in    = amp_ff;
      total_in  = total_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      ra_in     = ra_ff;
      rb_in     = rb_ff;
      fx_in     = fx_ff;
      fy_in     = fy_ff;
      fax_in    = fax_ff;
      fay_in    = fay_ff;
      cvx_in    = cvx_ff;
      cvy_in    = cvy_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      h00_in    = h00_ff;
      h01_in    = h01_ff;
      h10_in    = h10_ff;
      h11_in    = h11_ff;
      g00_in    = g00_ff;
      g01_in    = g01_ff;
      g10_in    = g10_ff;
      g11_in    = g11_ff;
      l0_in     = l0_ff;
      l1_in     = l1_ff;
      n_in      = n_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_noise_in = rsp_noise_ff;
      mul_op    = '0;
      tbl_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_type == pnoise_pkg::REQ_EVAL)) begin
               x_in     = req_x_coord;
               y_in     = req_y_coord;
               oct_in   = '0;
               total_in = '0;
               amp_in   = pnoise_pkg::ONE_Q16;
               rough_in = (csr_roughness_ff > pnoise_pkg::ONE_Q16) ?
                          pnoise_pkg::ONE_Q16 : csr_roughness_ff;
               if ({28'd0, csr_octave_count_ff} > 32'(MAX_OCTAVES)) begin
                  count_in = OCT_W'(MAX_OCTAVES);
               end else begin
                  count_in = OCT_W'(csr_octave_count_ff);
               end
               // With no octaves the sum is zero and goes straight out.
               state_in = (csr_octave_count_ff == 4'd0) ? S_DONE : S_PX;
            end
         end
         S_PX: begin
            mul_op.op_a = {x_ff[31], x_ff};
            mul_op.op_b = {1'b0, csr_base_scale_ff};
            state_in    = S_PY;
         end
         S_PY: begin
            px_in       = prod_ff;
            mul_op.op_a = {y_ff[31], y_ff};
            mul_op.op_b = {1'b0, csr_base_scale_ff};
            state_in    = S_PYW;
         end
         S_PYW: begin
            py_in    = prod_ff;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            cx_in    = sx[16 +: ADDR_W];
            cy_in    = sy[16 +: ADDR_W];
            fx_in    = sx[15:0];
            fy_in    = sy[15:0];
            state_in = S_STEP1;
         end
         S_STEP1: begin
            mul_op.op_a = {17'd0, fx_ff};
            mul_op.op_b = {9'd0, fx_ff};
            tbl_raddr   = cx_ff;
            state_in    = S_STEP2;
         end
         S_STEP2: begin
            fax_in      = prod_ff[31:16];
            ra_in       = rd_idx + cy_ff;
            mul_op.op_a = {17'd0, fy_ff};
            mul_op.op_b = {9'd0, fy_ff};
            tbl_raddr   = cx_ff + ADDR_W'(1);
            state_in    = S_STEP3;
         end
         S_STEP3: begin
            fay_in      = prod_ff[31:16];
            rb_in       = rd_idx + cy_ff;
            mul_op.op_a = {17'd0, fax_ff};
            mul_op.op_b = {9'd0, fx_ff};
            tbl_raddr   = ra_ff;
            state_in    = S_STEP4;
         end
         S_STEP4: begin
            fax_in      = prod_ff[31:16];
            mul_op.op_a = {17'd0, fay_ff};
            mul_op.op_b = {9'd0, fy_ff};
            tbl_raddr   = rd_idx;
            state_in    = S_STEP5;
         end
         S_STEP5: begin
            fay_in      = prod_ff[31:16];
            h00_in      = tbl_rdata_ff[3:0];
            mul_op.op_a = {17'd0, fx_ff};
            mul_op.op_b = poly_x;
            tbl_raddr   = ra_ff + ADDR_W'(1);
            state_in    = S_STEP6;
         end
         S_STEP6: begin
            cvx_in      = prod_ff[36:16] + pnoise_pkg::FADE_K10;
            mul_op.op_a = {17'd0, fy_ff};
            mul_op.op_b = poly_y;
            tbl_raddr   = rd_idx;
            state_in    = S_STEP7;
         end
         S_STEP7: begin
            cvy_in      = prod_ff[36:16] + pnoise_pkg::FADE_K10;
            h01_in      = tbl_rdata_ff[3:0];
            mul_op.op_a = {17'd0, fax_ff};
            mul_op.op_b = {4'd0, cvx_ff};
            tbl_raddr   = rb_ff;
            state_in    = S_STEP8;
         end
         S_STEP8: begin
            u_in        = prod_ff[32:16];
            mul_op.op_a = {17'd0, fay_ff};
            mul_op.op_b = {4'd0, cvy_ff};
            tbl_raddr   = rd_idx;
            state_in    = S_STEP9;
         end
         S_STEP9: begin
            v_in      = prod_ff[32:16];
            h10_in    = tbl_rdata_ff[3:0];
            mul_op    = grad_op(h00_ff, {1'b0, fx_ff}, {1'b0, fy_ff});
            tbl_raddr = rb_ff + ADDR_W'(1);
            state_in  = S_STEP10;
         end
         S_STEP10: begin
            g00_in    = prod_ff[23:0];
            mul_op    = grad_op(h01_ff, {1'b0, fx_ff}, {1'b1, fy_ff});
            tbl_raddr = rd_idx;
            state_in  = S_STEP11;
         end
         S_STEP11: begin
            g01_in   = prod_ff[23:0];
            h11_in   = tbl_rdata_ff[3:0];
            mul_op   = grad_op(h10_ff, {1'b1, fx_ff}, {1'b0, fy_ff});
            state_in = S_STEP12;
         end
         S_STEP12: begin
            g10_in   = prod_ff[23:0];
            mul_op   = grad_op(h11_ff, {1'b1, fx_ff}, {1'b1, fy_ff});
            state_in = S_STEP13;
         end
         S_STEP13: begin
            g11_in      = prod_ff[23:0];
            mul_op.op_a = {16'd0, u_ff};
            mul_op.op_b = {g10_ff[23], g10_ff} - {g00_ff[23], g00_ff};
            state_in    = S_STEP14;
         end
         S_STEP14: begin
            l0_in       = g00_ff + prod_ff[39:16];
            mul_op.op_a = {16'd0, u_ff};
            mul_op.op_b = {g11_ff[23], g11_ff} - {g01_ff[23], g01_ff};
            state_in    = S_STEP15;
         end
         S_STEP15: begin
            l1_in    = g01_ff + prod_ff[39:16];
            state_in = S_STEP16;
         end
         S_STEP16: begin
            mul_op.op_a = {16'd0, v_ff};
            mul_op.op_b = {l1_ff[23], l1_ff} - {l0_ff[23], l0_ff};
            state_in    = S_STEP17;
         end
         S_STEP17: begin
            n_in     = l0_ff + prod_ff[39:16];
            state_in = S_STEP18;
         end
         S_STEP18: begin
            mul_op.op_a = {{9{n_ff[23]}}, n_ff};
            mul_op.op_b = {8'd0, amp_ff};
            state_in    = S_STEP19;
         end
         S_STEP19: begin
            total_in    = total_ff + prod_ff[43:16];
            mul_op.op_a = {16'd0, amp_ff};
            mul_op.op_b = {8'd0, rough_ff};
            state_in    = S_STEP20;
         end
         S_STEP20: begin
            amp_in   = prod_ff[32:16];
            oct_in   = oct_next;
            state_in = (oct_next == count_ff) ? S_DONE : S_SHIFT;
         end
         S_DONE: begin
            // The result waits here only while the previous one is still unclaimed.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (total_ff > pnoise_pkg::NOISE_LIMIT) begin
                  rsp_noise_in = 24'(pnoise_pkg::NOISE_LIMIT);
               end else if (total_ff < -pnoise_pkg::NOISE_LIMIT) begin
                  rsp_noise_in = 24'(-pnoise_pkg::NOISE_LIMIT);
               end else begin
                  rsp_noise_in = total_ff[23:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= S_IDLE;
         rsp_valid_ff        <= 1'b0;
         csr_base_scale_ff   <= pnoise_pkg::BASE_RESET;
         csr_octave_count_ff <= pnoise_pkg::OCT_RESET;
         csr_roughness_ff    <= pnoise_pkg::ROUGH_RESET;
      end else begin
         state_ff            <= state_in;
         rsp_valid_ff        <= rsp_valid_in;
         csr_base_scale_ff   <= csr_base_scale_in;
         csr_octave_count_ff <= csr_octave_count_in;
         csr_roughness_ff    <= csr_roughness_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      count_ff     <= count_in;
      oct_ff       <= oct_in;
      rough_ff     <= rough_in;
      amp_ff       <= amp_in;
      total_ff     <= total_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      fax_ff       <= fax_in;
      fay_ff       <= fay_in;
      cvx_ff       <= cvx_in;
      cvy_ff       <= cvy_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      h00_ff       <= h00_in;
      h01_ff       <= h01_in;
      h10_ff       <= h10_in;
      h11_ff       <= h11_in;
      g00_ff       <= g00_in;
      g01_ff       <= g01_in;
      g10_ff       <= g10_in;
      g11_ff       <= g11_in;
      l0_ff        <= l0_in;
      l1_ff        <= l1_in;
      n_ff         <= n_in;
      rsp_noise_ff <= rsp_noise_in;
   end

   // The octave index stays below the octave count while a sample is in progress.
   `PN_ASSERT_IMPLIES(a_oct_range, clock, reset, (state_ff != S_IDLE) && (state_ff != S_DONE) && (state_ff != S_PX), oct_ff < count_ff, "octave index out of range")
   // The amplitude never grows past one.
   `PN_ASSERT_IMPLIES(a_amp_max, clock, reset, (state_ff != S_IDLE) && (state_ff != S_DONE), amp_ff <= pnoise_pkg::ONE_Q16, "amplitude above one")
   // A presented result is always saturated.
   `PN_ASSERT_IMPLIES(a_rsp_sat, clock, reset, rsp_valid_ff, (rsp_noise_ff <= 24'sd4194304) && (rsp_noise_ff >= -24'sd4194304), "result not saturated")
   // An accepted evaluate transfer starts the sequencer or finishes at once.
   `PN_ASSERT_NEXT(a_eval_start, clock, reset, req_xfer && (req_type == pnoise_pkg::REQ_EVAL), (state_ff == S_PX) || (state_ff == S_DONE), "evaluate transfer not started")

endmodule

`default_nettype wire

@@ tb/perlin_noise_2d_octaves_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and register ports of the noise core. It keeps its
// own copy of the permutation table and the registers, and works out the noise
// value of every evaluate transfer. Responses are compared in order.
module perlin_noise_2d_octaves_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_type,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [23:0] rsp_noise_value,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata,
   output int unsigned        error_count,
   output int unsigned        pending_count
);

   logic [7:0]  perm_copy [256];
   logic [23:0] scale_reg;
   logic [3:0]  octave_reg;
   logic [16:0] rough_reg;
   logic signed [23:0] noise_q [$];

   function automatic longint fade_q16(longint f);
      longint a, b, c;
      a = (f * f) >>> 16;
      b = (a * f) >>> 16;
      c = ((f * (6 * f - 15 * 65536)) >>> 16) + 10 * 65536;
      return (b * c) >>> 16;
   endfunction

   function automatic longint lerp_q16(longint t, longint a, longint b);
      return a + ((t * (b - a)) >>> 16);
   endfunction

   function automatic longint gradient(logic [7:0] h, longint dx, longint dy);
      longint m;
      m = 1 + longint'(h[2:0]);
      if (h[3]) m = -m;
      return (h[0] ? dx : dy) * m;
   endfunction

   function automatic longint octave_noise(longint px, longint py);
      logic [7:0] cx, cy, ra, rb;
      longint fx, fy, u, v;
      logic [7:0] h00, h01, h10, h11;
      cx = 8'((px >>> 16) & 255);
      cy = 8'((py >>> 16) & 255);
      fx = px & 64'hFFFF;
      fy = py & 64'hFFFF;
      u = fade_q16(fx);
      v = fade_q16(fy);
      ra = perm_copy[cx] + cy;
      rb = perm_copy[8'(cx + 8'd1)] + cy;
      h00 = perm_copy[perm_copy[ra]];
      h01 = perm_copy[perm_copy[8'(ra + 8'd1)]];
      h10 = perm_copy[perm_copy[rb]];
      h11 = perm_copy[perm_copy[8'(rb + 8'd1)]];
      return lerp_q16(v,
         lerp_q16(u, gradient(h00, fx, fy), gradient(h10, fx - 65536, fy)),
         lerp_q16(u, gradient(h01, fx, fy - 65536), gradient(h11, fx - 65536, fy - 65536)));
   endfunction

   function automatic logic signed [23:0] summed_noise(logic signed [31:0] x,
                                                       logic signed [31:0] y);
      longint px, py, total, amp, rough, n;
      int count;
      px = longint'(x) * longint'(scale_reg);
      py = longint'(y) * longint'(scale_reg);
      count = (octave_reg > 4'd8) ? 8 : int'(octave_reg);
      rough = (rough_reg > 17'd65536) ? 65536 : longint'(rough_reg);
      total = 0;
      amp = 65536;
      for (int i = 0; i < count; i++) begin
         n = octave_noise(px >>> (16 - i), py >>> (16 - i));
         total += (n * amp) >>> 16;
         amp = (amp * rough) >>> 16;
      end
      if (total > 4194304) total = 4194304;
      if (total < -4194304) total = -4194304;
      return total[23:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         scale_reg <= pnoise_pkg::BASE_RESET;
         octave_reg <= pnoise_pkg::OCT_RESET;
         rough_reg <= pnoise_pkg::ROUGH_RESET;
         noise_q.delete();
         error_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               pnoise_pkg::CSR_BASE_SCALE: begin
                  scale_reg <= csr_wdata;
               end
               pnoise_pkg::CSR_OCTAVE_COUNT: begin
                  octave_reg <= csr_wdata[3:0];
               end
               pnoise_pkg::CSR_ROUGHNESS: begin
                  rough_reg <= csr_wdata[16:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_type == pnoise_pkg::REQ_LOAD)
               perm_copy[req_table_index] = req_table_value;
            else
               noise_q.push_back(summed_noise(req_x_coord, req_y_coord));
         end
         if (rsp_valid && !rsp_stall) begin
            if (noise_q.size() == 0) begin
               $error("noise_value: unexpected response %0d", rsp_noise_value);
               error_count <= error_count + 1;
            end else if (noise_q[0] !== rsp_noise_value) begin
               $error("noise_value: expected %0d, got %0d", noise_q[0], rsp_noise_value);
               error_count <= error_count + 1;
               void'(noise_q.pop_front());
            end else begin
               void'(noise_q.pop_front());
            end
         end
      end
      pending_count <= noise_q.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

// Testbench of the octave noise core. The whole permutation table is loaded first,
// so that no evaluate can ever read an entry that was never written. Then come a
// few directed points and several phases of random traffic, each phase under its
// own register setting. The checker beside the core predicts every response.
module tb;

   // The register port has one index that maps to no register; writes there are ignored.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   // The settle time covers the longest evaluate, of eight octaves, still in flight.
   localparam int SETTLE_CYCLES = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_type = pnoise_pkg::REQ_LOAD;
   logic [7:0]         req_table_index = '0;
   logic [7:0]         req_table_value = '0;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [23:0] rsp_noise_value;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [23:0]        csr_wdata = '0;
   logic               long_hold_request = 1'b0;
   int unsigned        error_count;
   int unsigned        pending_count;

   always #6 clock = ~clock;

   perlin_noise_2d_octaves_core dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_table_index, .req_table_value,
      .req_x_coord, .req_y_coord,
      .rsp_valid, .rsp_stall, .rsp_noise_value,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   perlin_noise_2d_octaves_checker checker_inst (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_table_index, .req_table_value,
      .req_x_coord, .req_y_coord,
      .rsp_valid, .rsp_stall, .rsp_noise_value,
      .csr_wr_en, .csr_index, .csr_wdata,
      .error_count, .pending_count
   );

   // The receiver alternates between runs with no stall, short stalls and the odd
   // long one. Once asked, it also holds off for a long stretch so that the core
   // fills up and has to stall its own input.
   int  hold_left = 0;
   int  free_left = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (long_hold_request && !long_hold_done) begin
         long_hold_done = 1;
         hold_left = 600;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            free_left = $urandom_range(5, 80);
            rsp_stall <= 1'b0;
         end else if (pick < 92) begin
            hold_left = $urandom_range(0, 3);
            rsp_stall <= 1'b1;
         end else begin
            hold_left = $urandom_range(20, 120);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Offers one item and returns right after the edge at which it was taken.
   // Stall is looked at on the falling edge, where it is settled for the next edge.
   task automatic send_item(logic kind, logic [7:0] index, logic [7:0] value,
                            logic signed [31:0] x, logic signed [31:0] y);
      req_valid <= 1'b1;
      req_type <= kind;
      req_table_index <= index;
      req_table_value <= value;
      req_x_coord <= x;
      req_y_coord <= y;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly back to back, sometimes a short gap and rarely a long one.
   task automatic sender_gap();
      int pick, gap;
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(20, 80);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every response has come, then lets the core settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(logic [23:0] scale, logic [3:0] octaves,
                                  logic [16:0] rough);
      csr_wr_en <= 1'b1;
      csr_index <= pnoise_pkg::CSR_BASE_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= pnoise_pkg::CSR_OCTAVE_COUNT;
      csr_wdata <= {20'd0, octaves};
      @(posedge clock);
      csr_index <= pnoise_pkg::CSR_ROUGHNESS;
      csr_wdata <= {7'd0, rough};
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= 24'($urandom());
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) return $urandom();
      if (pick < 70) return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
      if (pick < 85) begin
         case ($urandom_range(0, 3))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $signed($urandom_range(0, 255) - 128) <<< 16;
   endfunction

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_item(pnoise_pkg::REQ_LOAD, 8'($urandom()), 8'($urandom()),
                      $urandom(), $urandom());
         else
            send_item(pnoise_pkg::REQ_EVAL, 8'($urandom()), 8'($urandom()),
                      random_coord(), random_coord());
         sender_gap();
      end
   endtask

   initial begin
      logic signed [31:0] points [8][2];
      points = '{'{32'sd0, 32'sd0}, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
                 '{32'sh8000_0000, 32'sh8000_0000}, '{32'sh8000_0000, 32'sh7FFF_FFFF},
                 '{-32'sd1, -32'sd1}, '{32'sh0000_8000, 32'sh0000_8000},
                 '{32'sh0000_FFFF, 32'sh0001_0000}, '{32'sh0003_4000, -32'sh0002_C000}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole table; the end entries also take the extreme values.
      for (int i = 0; i < 256; i++) begin
         send_item(pnoise_pkg::REQ_LOAD, i[7:0],
                   (i == 0) ? 8'd255 : (i == 255) ? 8'd0 : 8'($urandom()),
                   $urandom(), $urandom());
         sender_gap();
      end

      // Directed points under the reset setting.
      foreach (points[k]) begin
         send_item(pnoise_pkg::REQ_EVAL, 8'($urandom()), 8'($urandom()),
                   points[k][0], points[k][1]);
         sender_gap();
      end
      random_phase(120);

      // The sender pauses here until every response has come back.
      drain();
      write_registers(24'd65536, 4'd8, 17'd65536);
      random_phase(220);

      // Octave count beyond the maximum and roughness above one, under a long hold-off.
      drain();
      write_registers(24'hFF_FFFF, 4'd15, 17'h1_FFFF);
      long_hold_request <= 1'b1;
      random_phase(200);

      // Zero octaves and zero scale.
      drain();
      write_registers(24'd0, 4'd0, 17'd0);
      random_phase(150);

      drain();
      write_registers(24'($urandom_range(1, 24'h4_0000)), 4'($urandom_range(1, 8)),
                      17'($urandom_range(0, 17'h1_FFFF)));
      random_phase(250);

      drain();
      write_registers(24'($urandom()), 4'($urandom_range(0, 15)),
                      17'($urandom_range(0, 17'h1_FFFF)));
      random_phase(250);

      drain();
      write_registers(24'd1, 4'd1, 17'd65535);
      random_phase(150);

      drain();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
